### rtl/tci_pkg.sv
// Shared definitions for the thrust curve interpolator: field widths, codes,
// and the command and status structs that join the controller and datapath.
// No dependencies.
package tci_pkg;

   localparam int DATA_W       = 32;
   localparam int ACT_W        = 2;
   localparam int STAT_W       = 2;
   localparam int REQ_DATA_W   = 3 * DATA_W;
   localparam int RSP_DATA_W   = 2 * DATA_W;
   localparam int MAX_ROWS_DEF = 256;
   localparam int DIV_CNT_W    = $clog2(DATA_W + 1);

   // Request kinds carried on req_tuser.
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

   // Response status codes carried on rsp_tuser.
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   // Which table row the datapath reads next.
   typedef enum logic [1:0] {
      RD_FIRST,
      RD_LAST,
      RD_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic              load;          // capture the request transfer
      logic              clear_rows;    // empty the table
      logic              append;        // write a row at the fill position
      logic              res_init;      // zero the result, set its status
      logic [STAT_W-1:0] res_code;
      logic              rd_en;         // read one table row
      rd_sel_type        rd_sel;
      logic              take_row0;     // result is the row just read
      logic              take_last;     // thrust 0, mass of the row just read
      logic              shift_prev;    // row just read becomes the lower bracket
      logic              prep;          // form offset, span and magnitude
      logic              mul_go;        // register the product
      logic              div_go;        // start the divider
      logic              store_lerp;    // store the interpolated value
      logic              sel_mass_set;  // move on to the mass column
      logic              push;          // load the output register
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             count_zero;
      logic             count_full;
      logic             le_first;
      logic             ge_last;
      logic             bracket;
      logic             scan_end;
      logic             div_done;
      logic             out_free;
      logic             sel_mass;
   } stat_type;

endpackage

### rtl/tci_div.sv
// Restoring divider, one quotient bit per cycle, for a 64-bit dividend whose
// quotient is known to fit in 32 bits. Depends on tci_pkg.
module tci_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [2*tci_pkg::DATA_W-1:0]      dividend,
   input  logic [tci_pkg::DATA_W-1:0]        divisor,
   output logic                              done,
   output logic [tci_pkg::DATA_W-1:0]        quotient
);

   localparam int W = tci_pkg::DATA_W;

   logic                            busy_ff;
   logic                            done_ff;
   logic [tci_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [W-1:0]                    rem_ff;
   logic [W-1:0]                    lo_ff;
   logic [W-1:0]                    den_ff;
   logic [W:0]                      trial;
   logic                            fits;
   logic [W:0]                      diff;

   // The high half of the dividend is below the divisor, so the partial
   // remainder always fits in W bits after the subtract.
   assign trial = {rem_ff, lo_ff[W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= tci_pkg::DIV_CNT_W'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - tci_pkg::DIV_CNT_W'(1);
            if (cnt_ff == tci_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[2*W-1:W];
         lo_ff  <= dividend[W-1:0];
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[W-1:0] : trial[W-1:0];
         lo_ff  <= {lo_ff[W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = lo_ff;

endmodule

### rtl/tci_dpath.sv
// Datapath of the thrust curve interpolator: row tables, scan registers,
// multiplier, divider and the output register. Depends on tci_pkg, tci_div.
module tci_dpath #(
   parameter int MAX_ROWS = tci_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tci_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [tci_pkg::ACT_W-1:0]         req_tuser,
   input  tci_pkg::cmd_type                  cmd,
   output tci_pkg::stat_type                 stat,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tci_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [tci_pkg::STAT_W-1:0]        rsp_tuser
);

   localparam int W     = tci_pkg::DATA_W;
   localparam int IDX_W = $clog2(MAX_ROWS);
   localparam int CNT_W = $clog2(MAX_ROWS + 1);

   logic [W-1:0] time_mem   [MAX_ROWS];
   logic [W-1:0] thrust_mem [MAX_ROWS];
   logic [W-1:0] mass_mem   [MAX_ROWS];

   logic [tci_pkg::ACT_W-1:0]  act_ff;
   logic [W-1:0]               tv_ff, fv_ff, mv_ff;
   logic [CNT_W-1:0]           row_count_ff, row_count_in;
   logic [CNT_W-1:0]           last_wide;
   logic [IDX_W-1:0]           last_idx;
   logic [IDX_W-1:0]           scan_idx_ff;
   logic [IDX_W-1:0]           rd_addr;
   logic [W-1:0]               rd_t_ff, rd_f_ff, rd_m_ff;
   logic [W-1:0]               prev_t_ff, prev_f_ff, prev_m_ff;
   logic                       sel_mass_ff;
   logic [W-1:0]               v0, v1;
   logic [W-1:0]               off_ff, mag_ff, span_ff, v0_ff;
   logic                       neg_ff, span_zero_ff;
   logic [2*W-1:0]             prod_ff;
   logic                       div_done;
   logic [W-1:0]               quot;
   logic [W-1:0]               lerp;
   logic [W-1:0]               thr_res_ff, mass_res_ff;
   logic [tci_pkg::STAT_W-1:0] code_ff;
   logic                       out_valid_ff, out_valid_in;
   logic [W-1:0]               out_thr_ff, out_mass_ff;
   logic [tci_pkg::STAT_W-1:0] out_code_ff;

   assign last_wide = row_count_ff - CNT_W'(1);
   assign last_idx  = last_wide[IDX_W-1:0];

   always_comb begin
      case (cmd.rd_sel)
         tci_pkg::RD_FIRST: rd_addr = '0;
         tci_pkg::RD_LAST:  rd_addr = last_idx;
         tci_pkg::RD_NEXT:  rd_addr = scan_idx_ff + IDX_W'(1);
         default:           rd_addr = '0;
      endcase
   end

   always_comb begin
      row_count_in = row_count_ff;
      if (cmd.clear_rows) begin
         row_count_in = '0;
      end else if (cmd.append) begin
         row_count_in = row_count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
      end else begin
         row_count_ff <= row_count_in;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_tuser;
         tv_ff  <= req_tdata[W-1:0];
         fv_ff  <= req_tdata[2*W-1:W];
         mv_ff  <= req_tdata[3*W-1:2*W];
      end
   end

   // Row tables: one write port at the fill position, one registered read.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         time_mem[row_count_ff[IDX_W-1:0]]   <= tv_ff;
         thrust_mem[row_count_ff[IDX_W-1:0]] <= fv_ff;
         mass_mem[row_count_ff[IDX_W-1:0]]   <= mv_ff;
      end
      if (cmd.rd_en) begin
         rd_t_ff     <= time_mem[rd_addr];
         rd_f_ff     <= thrust_mem[rd_addr];
         rd_m_ff     <= mass_mem[rd_addr];
         scan_idx_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift_prev) begin
         prev_t_ff <= rd_t_ff;
         prev_f_ff <= rd_f_ff;
         prev_m_ff <= rd_m_ff;
      end
   end

   // Interpolation operands for the selected column.
   assign v0 = sel_mass_ff ? prev_m_ff : prev_f_ff;
   assign v1 = sel_mass_ff ? rd_m_ff   : rd_f_ff;

   always_ff @(posedge clock) begin
      if (cmd.res_init) begin
         sel_mass_ff <= 1'b0;
      end else if (cmd.sel_mass_set) begin
         sel_mass_ff <= 1'b1;
      end
      if (cmd.prep) begin
         off_ff       <= tv_ff - prev_t_ff;
         span_ff      <= rd_t_ff - prev_t_ff;
         span_zero_ff <= rd_t_ff == prev_t_ff;
         neg_ff       <= v1 < v0;
         mag_ff       <= (v1 < v0) ? v0 - v1 : v1 - v0;
         v0_ff        <= v0;
      end
      if (cmd.mul_go) begin
         prod_ff <= off_ff * mag_ff;
      end
   end

   tci_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (quot)
   );

   // A zero-width bracket keeps the earlier row's value.
   assign lerp = span_zero_ff ? v0_ff : (neg_ff ? v0_ff - quot : v0_ff + quot);

   always_ff @(posedge clock) begin
      if (cmd.res_init) begin
         thr_res_ff  <= '0;
         mass_res_ff <= '0;
         code_ff     <= cmd.res_code;
      end else if (cmd.take_row0) begin
         thr_res_ff  <= rd_f_ff;
         mass_res_ff <= rd_m_ff;
      end else if (cmd.take_last) begin
         thr_res_ff  <= '0;
         mass_res_ff <= rd_m_ff;
      end else if (cmd.store_lerp) begin
         if (sel_mass_ff) begin
            mass_res_ff <= lerp;
         end else begin
            thr_res_ff <= lerp;
         end
      end
   end

   // Output register.
   assign out_valid_in = cmd.push | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_thr_ff  <= thr_res_ff;
         out_mass_ff <= mass_res_ff;
         out_code_ff <= code_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_mass_ff, out_thr_ff};
   assign rsp_tuser  = out_code_ff;

   assign stat.action     = act_ff;
   assign stat.count_zero = row_count_ff == '0;
   assign stat.count_full = row_count_ff == CNT_W'(MAX_ROWS);
   assign stat.le_first   = tv_ff <= rd_t_ff;
   assign stat.ge_last    = tv_ff >= rd_t_ff;
   assign stat.bracket    = (tv_ff >= prev_t_ff) && (tv_ff <= rd_t_ff);
   assign stat.scan_end   = scan_idx_ff == last_idx;
   assign stat.div_done   = div_done;
   assign stat.out_free   = ~out_valid_ff | rsp_tready;
   assign stat.sel_mass   = sel_mass_ff;

endmodule

### rtl/tci_ctrl.sv
// Controller of the thrust curve interpolator: sequences clear, append and
// query through the datapath by command and status. Depends on tci_pkg.
module tci_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output tci_pkg::cmd_type   cmd,
   input  tci_pkg::stat_type  stat
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_Q_FIRST,
      S_Q_LAST,
      S_PRIME,
      S_SCAN,
      S_PREP,
      S_MUL,
      S_DIV_GO,
      S_DIV_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_code = tci_pkg::ST_OK;
      cmd.rd_sel   = tci_pkg::RD_FIRST;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.res_init = 1'b1;
            state_in     = S_FINISH;
            case (stat.action)
               tci_pkg::ACT_CLEAR: begin
                  cmd.clear_rows = 1'b1;
               end
               tci_pkg::ACT_APPEND: begin
                  if (stat.count_full) begin
                     cmd.res_code = tci_pkg::ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               tci_pkg::ACT_QUERY: begin
                  if (stat.count_zero) begin
                     cmd.res_code = tci_pkg::ST_EMPTY;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_Q_FIRST;
                  end
               end
               default: begin
               end
            endcase
         end
         S_Q_FIRST: begin
            if (stat.le_first) begin
               cmd.take_row0 = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = tci_pkg::RD_LAST;
               state_in   = S_Q_LAST;
            end
         end
         S_Q_LAST: begin
            // Past-the-end answer stands unless a bracket turns up.
            cmd.take_last = 1'b1;
            if (stat.ge_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_PRIME;
            end
         end
         S_PRIME: begin
            cmd.shift_prev = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = tci_pkg::RD_NEXT;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            if (stat.bracket) begin
               state_in = S_PREP;
            end else if (stat.scan_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.shift_prev = 1'b1;
               cmd.rd_en      = 1'b1;
               cmd.rd_sel     = tci_pkg::RD_NEXT;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_go = 1'b1;
            state_in   = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.store_lerp = 1'b1;
               if (stat.sel_mass) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.sel_mass_set = 1'b1;
                  state_in         = S_PREP;
               end
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### rtl/thrust_curve_interpolator.sv
// Top level of the thrust curve interpolator: ties the controller to the
// datapath. Depends on tci_pkg, tci_ctrl, tci_dpath (and tci_div below it).
//
// The block holds a thrust curve of up to MAX_ROWS rows of time, thrust and
// propellant mass, all unsigned Q16.16, and answers queries by piecewise
// linear interpolation. Each request transfer produces exactly one response
// transfer. A clear empties the table; an append writes the next row, or
// reports status 1 and drops the row when the table is full; a query returns
// row 0 at or before the first time, thrust 0 and the last mass at or past
// the last time, and otherwise interpolates within the first bracketing row
// pair, truncating the step from the earlier row's value toward zero. A
// query on an empty table reports status 2. Rows must be appended in time
// order; if no bracket is found the past-the-end answer is returned. Items
// are handled one at a time. The time a query takes is set by the linear
// scan, which reads one row per cycle from the single table read port, and
// by the shared restoring divider, which works out the two interpolated values
// one after the other. A finished response waits in the output register, and
// the next request transfer is accepted while it waits.
module thrust_curve_interpolator #(
   parameter int MAX_ROWS = tci_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // From bit 0: time_value[31:0], thrust_value[63:32], mass_value[95:64].
   input  logic [tci_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action[1:0]: 0 clear, 1 append, 2 query.
   input  logic [tci_pkg::ACT_W-1:0]         req_tuser,
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // From bit 0: thrust_out[31:0], mass_out[63:32].
   output logic [tci_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status[1:0]: 0 ok, 1 table full and row dropped, 2 query on empty table.
   output logic [tci_pkg::STAT_W-1:0]        rsp_tuser
);

   tci_pkg::cmd_type  cmd;
   tci_pkg::stat_type stat;

   // The controller sequences each transfer through the datapath.
   tci_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // The datapath holds the tables, arithmetic and the output register.
   tci_dpath #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
